[hw/rtl/uepca_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uepca_pkg: shared types and constants of the endpoint channel allocator
// Request kinds, sequencer states, channel table records and fixed values.
// ----------------------------------------------------------------------------
package uepca_pkg;

  localparam int CHANNELS         = 8;
  localparam int EP0_BUFFER_BYTES = 64;
  localparam int IDX_W            = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // unassigned marks and transfer types
  localparam logic [4:0] NO_EP          = 5'h1F;
  localparam logic [2:0] NO_TYPE        = 3'h7;
  localparam logic [1:0] TYPE_BULK      = 2'd2;
  localparam logic [1:0] TYPE_INTERRUPT = 2'd3;

  // bump pointer start points
  localparam logic [15:0] NEXT_FREE_RESET = 16'(8 * CHANNELS);
  localparam logic [15:0] NEXT_FREE_CLOSE = 16'(8 * CHANNELS + 2 * EP0_BUFFER_BYTES);

  typedef enum logic [2:0] {
    KIND_RESET     = 3'd0,
    KIND_ASSIGN    = 3'd1,
    KIND_OPEN      = 3'd2,
    KIND_CLOSE_ALL = 3'd3,
    KIND_RESERVE   = 3'd4
  } kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  // one channel record
  typedef struct packed {
    logic [4:0] endpoint;
    logic [2:0] ctype;
    logic       out_taken;
    logic       in_taken;
  } chan_entry_t;

  // table command from the sequencer
  typedef struct packed {
    logic             clear_all;
    logic             clear_upper;
    logic             claim;
    logic             is_in;
    logic [IDX_W-1:0] idx;
    logic [4:0]       endpoint;
    logic [2:0]       ctype;
  } tbl_cmd_t;

endpackage

[hw/rtl/uepca_chan_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uepca_chan_table: per-channel endpoint records
// Holds endpoint number, type and direction flags for each channel; one
// record is read at the scan index, claimed or bulk-cleared on command.
// ----------------------------------------------------------------------------
module uepca_chan_table (
  input  logic                  clk,
  input  logic                  rst,
  input  uepca_pkg::tbl_cmd_t   cmd,
  output uepca_pkg::chan_entry_t entry
);

  uepca_pkg::chan_entry_t chan [uepca_pkg::CHANNELS];

  // record at the scan index
  assign entry = chan[cmd.idx];

  // record updates
  always_ff @(posedge clk) begin
    for (int c = 0; c < uepca_pkg::CHANNELS; c++) begin
      if (rst || cmd.clear_all || (cmd.clear_upper && c != 0)) begin
        chan[c].endpoint  <= uepca_pkg::NO_EP;
        chan[c].ctype     <= uepca_pkg::NO_TYPE;
        chan[c].out_taken <= 1'b0;
        chan[c].in_taken  <= 1'b0;
      end else if (cmd.claim && cmd.idx == uepca_pkg::IDX_W'(c)) begin
        chan[c].endpoint <= cmd.endpoint;
        chan[c].ctype    <= cmd.ctype;
        if (cmd.is_in) begin
          chan[c].in_taken <= 1'b1;
        end else begin
          chan[c].out_taken <= 1'b1;
        end
      end
    end
  end

endmodule

[hw/rtl/usb_endpoint_channel_allocator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_endpoint_channel_allocator_unit: USB endpoint to channel allocator
// Maps endpoint open requests onto hardware channels and bump-allocates
// packet-memory buffers.
// ----------------------------------------------------------------------------
// Usage:
//   A request word (kind, ep_address, ep_type, alloc_bytes) is taken at a
//   rising edge with start high and busy low. Exactly one result word (ok,
//   channel, buffer_addr) follows, shown for one cycle with done high; the
//   receiver has no way to hold it off and must take it then.
//   Reset, close-all, reserve and unused kinds finish at once: done rises
//   in the cycle after the request is taken and busy stays low.
//   Assign and open run a first-fit scan, one channel per cycle through a
//   single compare unit, and raise done once a channel fits or the last
//   channel has been checked. busy is high during the scan, so no new
//   request is taken until the scan has ended.
//   rst clears every channel record, sets the buffer pointer to
//   8*CHANNELS, drops busy and suppresses done.
// ----------------------------------------------------------------------------
module usb_endpoint_channel_allocator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind,
  input  logic [7:0]  ep_address,
  input  logic [1:0]  ep_type,
  input  logic [10:0] alloc_bytes,
  output logic        done,
  output logic        ok,
  output logic [2:0]  channel,
  output logic [15:0] buffer_addr
);

  uepca_pkg::state_t state, state_next;
  uepca_pkg::kind_t  kind_q;
  logic [7:0]        addr_q;
  logic [1:0]        type_q;
  logic [10:0]       size_q;
  logic [uepca_pkg::IDX_W-1:0] idx, idx_next;
  logic [15:0]       next_free, next_free_next;
  logic              done_next, ok_next;
  logic [2:0]        channel_next;
  logic [15:0]       buffer_addr_next;

  uepca_pkg::tbl_cmd_t    cmd;
  uepca_pkg::chan_entry_t entry;

  logic       accept;
  logic [4:0] num5;
  logic [2:0] type3;
  logic       is_in, taken, reuse, claim, hit, type_ok;

  assign accept = start && !busy;
  assign busy   = (state == uepca_pkg::ST_SCAN);

  uepca_chan_table u_table (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .entry (entry)
  );

  // shared compare unit, one channel per cycle
  assign num5    = {1'b0, addr_q[3:0]};
  assign type3   = {1'b0, type_q};
  assign is_in   = addr_q[7];
  assign taken   = is_in ? entry.in_taken : entry.out_taken;
  assign reuse   = taken && entry.ctype == type3 && entry.endpoint == num5;
  assign claim   = !taken &&
                   (entry.endpoint == uepca_pkg::NO_EP || entry.endpoint == num5) &&
                   (entry.ctype == uepca_pkg::NO_TYPE || entry.ctype == type3);
  assign hit     = reuse || claim;
  assign type_ok = (type_q == uepca_pkg::TYPE_BULK) ||
                   (type_q == uepca_pkg::TYPE_INTERRUPT);

  // request latch
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= uepca_pkg::kind_t'(kind);
      addr_q <= ep_address;
      type_q <= ep_type;
      size_q <= alloc_bytes;
    end
  end

  // state, pointer and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= uepca_pkg::ST_IDLE;
      idx       <= '0;
      next_free <= uepca_pkg::NEXT_FREE_RESET;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      next_free <= next_free_next;
      done      <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    ok          <= ok_next;
    channel     <= channel_next;
    buffer_addr <= buffer_addr_next;
  end

  // sequencer
  always_comb begin
    state_next       = state;
    idx_next         = idx;
    next_free_next   = next_free;
    done_next        = 1'b0;
    ok_next          = 1'b0;
    channel_next     = '0;
    buffer_addr_next = '0;

    cmd.clear_all   = 1'b0;
    cmd.clear_upper = 1'b0;
    cmd.claim       = 1'b0;
    cmd.is_in       = is_in;
    cmd.idx         = idx;
    cmd.endpoint    = num5;
    cmd.ctype       = type3;

    unique case (state)
      uepca_pkg::ST_IDLE: begin
        if (accept) begin
          case (uepca_pkg::kind_t'(kind))
            uepca_pkg::KIND_RESET: begin
              cmd.clear_all  = 1'b1;
              next_free_next = uepca_pkg::NEXT_FREE_RESET;
              done_next      = 1'b1;
              ok_next        = 1'b1;
            end
            uepca_pkg::KIND_ASSIGN, uepca_pkg::KIND_OPEN: begin
              idx_next   = '0;
              state_next = uepca_pkg::ST_SCAN;
            end
            uepca_pkg::KIND_CLOSE_ALL: begin
              cmd.clear_upper = 1'b1;
              next_free_next  = uepca_pkg::NEXT_FREE_CLOSE;
              done_next       = 1'b1;
              ok_next         = 1'b1;
            end
            uepca_pkg::KIND_RESERVE: begin
              buffer_addr_next = next_free;
              next_free_next   = next_free + 16'(alloc_bytes);
              done_next        = 1'b1;
              ok_next          = 1'b1;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      uepca_pkg::ST_SCAN: begin
        cmd.claim = claim;
        if (hit) begin
          state_next = uepca_pkg::ST_IDLE;
          done_next  = 1'b1;
          if (kind_q == uepca_pkg::KIND_ASSIGN) begin
            ok_next      = 1'b1;
            channel_next = 3'(idx);
          end else if (type_ok) begin
            ok_next          = 1'b1;
            channel_next     = 3'(idx);
            buffer_addr_next = next_free;
            next_free_next   = next_free + 16'(size_q);
          end
        end else if (idx == uepca_pkg::IDX_W'(uepca_pkg::CHANNELS - 1)) begin
          // no channel fits
          state_next = uepca_pkg::ST_IDLE;
          done_next  = 1'b1;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      default: begin
        state_next = uepca_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // results appear only once the sequencer is back at rest
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == uepca_pkg::ST_IDLE)
    else $error("result strobed during a scan");

  // every taken request either answers next cycle or starts a scan
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> (done || busy))
    else $error("request taken but neither answered nor scanning");

  // a failed request carries no channel and no buffer
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !ok) |-> (channel == 3'd0 && buffer_addr == 16'd0))
    else $error("failed result carries payload");

  // only assign and open requests scan
  a_scan_kind: assert property (@(posedge clk) disable iff (rst)
    busy |-> (kind_q == uepca_pkg::KIND_ASSIGN || kind_q == uepca_pkg::KIND_OPEN))
    else $error("scan running for a kind that does not assign");
`endif

endmodule
